[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the resume time checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define NPRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define NPRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/nprt_pkg.sv]
// ----------------------------------------------------------------------------
// nprt_pkg
// Item types, widths and time constants for the next resume time pipeline.
// ----------------------------------------------------------------------------
package nprt_pkg;

  localparam int SECS_PER_MIN  = 60;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_DAY  = 24 * 60 * 60;
  localparam int HOURS_PER_DAY = 24;

  localparam int HOUR_W    = 5;
  localparam int MS_W      = 6;   // minute / second field width
  localparam int PERIOD_W  = 17;
  localparam int DAY_W     = 17;  // seconds of day, out-of-range fields included
  localparam int ELAPSED_W = 32;  // wraps modulo 2^32
  localparam int T_W       = 18;  // period - rem + cur

  // remainder pipeline
  localparam int REM_STEP_BITS = 2;
  localparam int REM_STAGES    = ELAPSED_W / REM_STEP_BITS;

  // t / 3600 by reciprocal, at most one short
  localparam int HR_RECIP   = 298261;  // floor(2^30 / 3600)
  localparam int HR_RECIP_W = 19;
  localparam int HR_SHIFT   = 30;
  localparam int QH_W       = 7;       // t / 3600 <= 68

  // r / 60 by reciprocal, at most one short
  localparam int MIN_RECIP   = 1092;   // floor(2^16 / 60)
  localparam int MIN_RECIP_W = 11;
  localparam int MIN_SHIFT   = 16;
  localparam int RH_W        = 12;     // remainder below one hour

  typedef struct packed {
    logic [HOUR_W-1:0]   resume_hour;
    logic [MS_W-1:0]     resume_minute;
    logic [MS_W-1:0]     resume_second;
    logic [HOUR_W-1:0]   now_hour;
    logic [MS_W-1:0]     now_minute;
    logic [MS_W-1:0]     now_second;
    logic [PERIOD_W-1:0] period_seconds;
  } in_item_t;

  typedef struct packed {
    logic [HOUR_W-1:0] next_hour;
    logic [MS_W-1:0]   next_minute;
    logic [MS_W-1:0]   next_second;
    logic              period_error;
  } out_item_t;

  // front end -> remainder pipeline
  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic [DAY_W-1:0]     cur;
    logic [PERIOD_W-1:0]  period;
    logic                 err;
  } front_t;

  // remainder pipeline -> time split
  typedef struct packed {
    logic [PERIOD_W-1:0] rem;
    logic [DAY_W-1:0]    cur;
    logic [PERIOD_W-1:0] period;
    logic                err;
  } rem_res_t;

endpackage

[rtl/next_periodic_resume_time.sv]
// ----------------------------------------------------------------------------
// next_periodic_resume_time
// Next resume time of a periodic event from the last resume time, the
// current time of day and the period.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------
//   in      | input     | in_valid_i / in_ready_o | in_item_i  (in_item_t)
//   out     | output    | out_valid_o/out_ready_i | out_item_o (out_item_t)
//
// One item per cycle while the skid slot is free; items pass the remainder
// pipeline (16 stages, 2 dividend bits each) plus 2 front, 4 split stages
// and the output register.
// Reset clears the valid bits only; no clearing pass, ready right after reset.
// Stall: the whole pipe holds while the skid slot is full; ready drops once an
// item fills the slot while the output is held back, and nothing is lost.
// ----------------------------------------------------------------------------
module next_periodic_resume_time (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nprt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nprt_pkg::out_item_t out_item_o
);

  // single pipe enable: advance whenever the output side can take an item
  logic en;

  logic                fr_valid, rm_valid, sp_valid;
  nprt_pkg::front_t    fr_data;
  nprt_pkg::rem_res_t  rm_data;
  nprt_pkg::out_item_t sp_item;

  assign in_ready_o = en;

  // seconds of day and elapsed time, midnight wrap included
  nprt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .valid_o (fr_valid),
    .front_o (fr_data)
  );

  // elapsed mod period; a zero period only yields junk here, flagged by err
  nprt_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .front_i (fr_data),
    .valid_o (rm_valid),
    .res_o   (rm_data)
  );

  // t = period - rem + cur, then hour (mod 24), minute, second
  nprt_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rm_valid),
    .res_i   (rm_data),
    .valid_o (sp_valid),
    .item_o  (sp_item)
  );

  // output register plus skid slot parts the pipe from the consumer
  nprt_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (sp_valid),
    .up_ready_o (en),
    .up_item_i  (sp_item),
    .dn_valid_o (out_valid_o),
    .dn_ready_i (out_ready_i),
    .dn_item_o  (out_item_o)
  );

endmodule

[rtl/nprt_front.sv]
// ----------------------------------------------------------------------------
// nprt_front
// Seconds of day for both times, then the elapsed time across midnight.
// Two register stages.
// ----------------------------------------------------------------------------
module nprt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  nprt_pkg::in_item_t  item_i,
  output logic                valid_o,
  output nprt_pkg::front_t    front_o
);

  localparam int DW = nprt_pkg::DAY_W;
  localparam int EW = nprt_pkg::ELAPSED_W;

  logic [DW-1:0] res_d, cur_d, res_q, cur_q;
  logic [nprt_pkg::PERIOD_W-1:0] per_q;
  logic err_q, v1_q, v2_q;
  nprt_pkg::front_t front_d, front_q;

  assign res_d = DW'(item_i.resume_second)
               + DW'(item_i.resume_minute) * DW'(nprt_pkg::SECS_PER_MIN)
               + DW'(item_i.resume_hour) * DW'(nprt_pkg::SECS_PER_HOUR);
  assign cur_d = DW'(item_i.now_second)
               + DW'(item_i.now_minute) * DW'(nprt_pkg::SECS_PER_MIN)
               + DW'(item_i.now_hour) * DW'(nprt_pkg::SECS_PER_HOUR);

  always_comb begin
    front_d.cur    = cur_q;
    front_d.period = per_q;
    front_d.err    = err_q;
    if (cur_q < res_q) begin
      front_d.elapsed = EW'(nprt_pkg::SECS_PER_DAY) - EW'(res_q) + EW'(cur_q);
    end else begin
      front_d.elapsed = EW'(cur_q) - EW'(res_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q   <= res_d;
      cur_q   <= cur_d;
      per_q   <= item_i.period_seconds;
      err_q   <= (item_i.period_seconds == '0);
      front_q <= front_d;
    end
  end

  assign valid_o = v2_q;
  assign front_o = front_q;

endmodule

[rtl/nprt_rem.sv]
// ----------------------------------------------------------------------------
// nprt_rem
// Pipelined restoring remainder: elapsed mod period, a few dividend bits
// per register stage.
// ----------------------------------------------------------------------------
module nprt_rem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  nprt_pkg::front_t   front_i,
  output logic               valid_o,
  output nprt_pkg::rem_res_t res_o
);

  localparam int NSTG = nprt_pkg::REM_STAGES;
  localparam int SB   = nprt_pkg::REM_STEP_BITS;
  localparam int PW   = nprt_pkg::PERIOD_W;
  localparam int EW   = nprt_pkg::ELAPSED_W;

  typedef struct packed {
    logic [EW-1:0]                dvd;  // dividend bits still to consume, msb first
    logic [PW-1:0]                rem;
    logic [nprt_pkg::DAY_W-1:0]   cur;
    logic [PW-1:0]                period;
    logic                         err;
  } stage_t;

  function automatic logic [PW-1:0] rem_step(input logic [PW-1:0] r,
                                             input logic [SB-1:0] b,
                                             input logic [PW-1:0] d);
    logic [PW:0]   x;
    logic [PW-1:0] acc;
    acc = r;
    for (int i = SB - 1; i >= 0; i--) begin
      x = {acc, b[i]};
      if (x >= {1'b0, d}) begin
        x = x - {1'b0, d};
      end
      acc = x[PW-1:0];
    end
    return acc;
  endfunction

  stage_t stg_q [NSTG];
  logic   vld_q [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    stage_t src, nxt;
    logic   src_v;

    if (k == 0) begin : g_first
      assign src.dvd    = front_i.elapsed;
      assign src.rem    = '0;
      assign src.cur    = front_i.cur;
      assign src.period = front_i.period;
      assign src.err    = front_i.err;
      assign src_v      = valid_i;
    end else begin : g_next
      assign src   = stg_q[k-1];
      assign src_v = vld_q[k-1];
    end

    always_comb begin
      nxt     = src;
      nxt.rem = rem_step(src.rem, src.dvd[EW-1 -: SB], src.period);
      nxt.dvd = src.dvd << SB;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= nxt;
      end
    end
  end

  assign valid_o      = vld_q[NSTG-1];
  assign res_o.rem    = stg_q[NSTG-1].rem;
  assign res_o.cur    = stg_q[NSTG-1].cur;
  assign res_o.period = stg_q[NSTG-1].period;
  assign res_o.err    = stg_q[NSTG-1].err;

endmodule

[rtl/nprt_split.sv]
// ----------------------------------------------------------------------------
// nprt_split
// Next resume time in seconds, then hour, minute and second by reciprocal
// multiplies with one correction each. Four register stages.
// ----------------------------------------------------------------------------
module nprt_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  nprt_pkg::rem_res_t  res_i,
  output logic                valid_o,
  output nprt_pkg::out_item_t item_o
);

  localparam int TW  = nprt_pkg::T_W;
  localparam int QW  = nprt_pkg::QH_W;
  localparam int RW  = nprt_pkg::RH_W;
  localparam int MW  = nprt_pkg::MS_W;
  localparam int HW  = nprt_pkg::HOUR_W;
  localparam int HPW = TW + nprt_pkg::HR_RECIP_W;
  localparam int MPW = RW + nprt_pkg::MIN_RECIP_W;

  logic v1_q, v2_q, v3_q, v4_q;
  logic e1_q, e2_q, e3_q, e4_q;

  // stage 1: t
  logic [TW-1:0] t1_d, t1_q;
  // stage 2: hour estimate
  logic [HPW-1:0] hprod;
  logic [TW-1:0]  t2_q;
  logic [QW-1:0]  qe_q;
  // stage 3: corrected hours and remainder
  logic [TW-1:0]  hdiff, hdiff_c;
  logic [QW-1:0]  qh_d, qh_q;
  logic [RW-1:0]  rh_d, rh3_q;
  // stage 4: hour of day, minute estimate
  logic [QW-1:0]  hq;
  logic [MPW-1:0] mprod;
  logic [HW-1:0]  hr_q;
  logic [MW-1:0]  me_q;
  logic [RW-1:0]  rh4_q;
  // output logic
  logic [RW-1:0]  sdiff;
  logic [MW-1:0]  mm;
  logic [MW-1:0]  ss;

  assign t1_d = TW'(res_i.period) - TW'(res_i.rem) + TW'(res_i.cur);

  assign hprod = HPW'(t1_q) * HPW'(nprt_pkg::HR_RECIP);

  always_comb begin
    hdiff   = t2_q - TW'(qe_q) * TW'(nprt_pkg::SECS_PER_HOUR);
    hdiff_c = hdiff - TW'(nprt_pkg::SECS_PER_HOUR);
    if (hdiff >= TW'(nprt_pkg::SECS_PER_HOUR)) begin
      qh_d = qe_q + QW'(1);
      rh_d = hdiff_c[RW-1:0];
    end else begin
      qh_d = qe_q;
      rh_d = hdiff[RW-1:0];
    end
  end

  always_comb begin
    if (qh_q >= QW'(2 * nprt_pkg::HOURS_PER_DAY)) begin
      hq = qh_q - QW'(2 * nprt_pkg::HOURS_PER_DAY);
    end else if (qh_q >= QW'(nprt_pkg::HOURS_PER_DAY)) begin
      hq = qh_q - QW'(nprt_pkg::HOURS_PER_DAY);
    end else begin
      hq = qh_q;
    end
  end

  assign mprod = MPW'(rh3_q) * MPW'(nprt_pkg::MIN_RECIP);

  always_comb begin
    sdiff = rh4_q - RW'(me_q) * RW'(nprt_pkg::SECS_PER_MIN);
    if (sdiff >= RW'(nprt_pkg::SECS_PER_MIN)) begin
      mm = me_q + MW'(1);
      ss = MW'(sdiff - RW'(nprt_pkg::SECS_PER_MIN));
    end else begin
      mm = me_q;
      ss = MW'(sdiff);
    end
    item_o.period_error = e4_q;
    if (e4_q) begin
      item_o.next_hour   = '0;
      item_o.next_minute = '0;
      item_o.next_second = '0;
    end else begin
      item_o.next_hour   = hr_q;
      item_o.next_minute = mm;
      item_o.next_second = ss;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q  <= t1_d;
      e1_q  <= res_i.err;
      t2_q  <= t1_q;
      qe_q  <= hprod[nprt_pkg::HR_SHIFT +: QW];
      e2_q  <= e1_q;
      qh_q  <= qh_d;
      rh3_q <= rh_d;
      e3_q  <= e2_q;
      hr_q  <= hq[HW-1:0];
      me_q  <= mprod[nprt_pkg::MIN_SHIFT +: MW];
      rh4_q <= rh3_q;
      e4_q  <= e3_q;
    end
  end

  assign valid_o = v4_q;

endmodule

[rtl/nprt_skid.sv]
// ----------------------------------------------------------------------------
// nprt_skid
// Output register with one skid slot; upstream ready is registered.
// ----------------------------------------------------------------------------
module nprt_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                up_valid_i,
  output logic                up_ready_o,
  input  nprt_pkg::out_item_t up_item_i,
  output logic                dn_valid_o,
  input  logic                dn_ready_i,
  output nprt_pkg::out_item_t dn_item_o
);

  logic out_valid_q, skid_valid_q, up_fire, out_free;
  nprt_pkg::out_item_t out_q, skid_q;

  assign up_ready_o = !skid_valid_q;
  assign up_fire    = up_valid_i && !skid_valid_q;
  assign out_free   = dn_ready_i || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || up_fire;
      skid_valid_q <= 1'b0;
    end else if (up_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : up_item_i;
    end else if (up_fire) begin
      skid_q <= up_item_i;
    end
  end

  assign dn_valid_o = out_valid_q;
  assign dn_item_o  = out_q;

endmodule

[rtl/nprt_checker.sv]
// ----------------------------------------------------------------------------
// nprt_checker
// Port-level checks on the resume time block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nprt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input nprt_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input nprt_pkg::out_item_t out_item_o
);

  logic time_zero, time_ok;
  assign time_zero = out_item_o.next_hour == '0 && out_item_o.next_minute == '0
                     && out_item_o.next_second == '0;
  assign time_ok   = out_item_o.next_hour < 5'd24 && out_item_o.next_minute < 6'd60
                     && out_item_o.next_second < 6'd60;

  // held output item stays put
  `NPRT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o), "output item changed while stalled")

  // error items carry a zero time
  `NPRT_ASSERT(a_err_zero, out_valid_o && out_item_o.period_error |-> time_zero, "error item with nonzero time")

  // good items are a valid time of day
  `NPRT_ASSERT(a_range, out_valid_o && !out_item_o.period_error |-> time_ok, "time field out of range")

  // input side only stalls behind a held output item
  `NPRT_ASSERT(a_stall_cause, !in_ready_o |-> out_valid_o, "input stalled with empty output")

  // nothing leaves during reset
  `NPRT_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

bind next_periodic_resume_time nprt_checker u_chk (.*);
